@@ rtl/brb_pkg.sv @@
// Package for the byte ring buffer: store geometry, command codes and beat types.
// No dependencies; used by every module in rtl.
`timescale 1ns / 1ps

package brb_pkg;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = 4;
  localparam int unsigned LaneW    = $clog2(MaxBytes);
  localparam int unsigned DataW    = 64;

  localparam logic FuncPush = 1'b0;
  localparam logic FuncPop  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [CntW-1:0]  byte_count;
    logic [DataW-1:0] push_bytes;
  } brb_req_t;

  typedef struct packed {
    logic             accepted;
    logic [DataW-1:0] popped_bytes;
    logic [IdxW-1:0]  fill_level;
  } brb_rsp_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } brb_mem_cmd_t;

endpackage

@@ rtl/brb_mem.sv @@
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on brb_pkg.
`timescale 1ns / 1ps

module brb_mem
  import brb_pkg::*;
(
  input  logic         clk_i,
  input  brb_mem_cmd_t cmd_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/brb_ctrl.sv @@
// Sequencer of the ring buffer: checks room or fill, then moves one byte per
// cycle through the shared pointer incrementer. Depends on brb_pkg.
`timescale 1ns / 1ps

module brb_ctrl
  import brb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  brb_req_t     req_i,
  input  logic [7:0]   rdata_i,
  output logic         busy_o,
  output logic         done_o,
  output brb_rsp_t     rsp_o,
  output brb_mem_cmd_t mem_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StPush  = 3'd2;
  localparam logic [2:0] StPop   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             func_q, func_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [DataW-1:0] data_q, data_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  wr_q, wr_d;
  logic [IdxW-1:0]  rd_q, rd_d;
  logic             ok_q, ok_d;
  logic             rvld_q, rvld_d;
  logic [LaneW-1:0] rlane_q, rlane_d;
  logic [DataW-1:0] popped_q, popped_d;

  logic [IdxW-1:0]  fill;
  logic [IdxW-1:0]  room;
  logic [IdxW-1:0]  count_ext;
  logic             issue;
  logic [IdxW-1:0]  new_wr;
  logic [IdxW-1:0]  new_rd;

  assign fill      = wr_q - rd_q;
  assign room      = ~fill;
  assign count_ext = {{(IdxW-CntW){1'b0}}, count_q};
  assign issue     = (cnt_q != count_q);
  assign new_wr    = (ok_q && func_q == FuncPush) ? ptr_q : wr_q;
  assign new_rd    = (ok_q && func_q == FuncPop) ? ptr_q : rd_q;

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    count_d  = count_q;
    data_d   = data_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    ok_d     = ok_q;
    rvld_d   = 1'b0;
    rlane_d  = rlane_q;
    popped_d = popped_q;
    mem_o    = '0;
    done_o   = 1'b0;

    if (rvld_q) begin
      popped_d[{rlane_q, 3'b000} +: 8] = rdata_i;
    end

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d  = req_i.func;
          count_d = req_i.byte_count;
          data_d  = req_i.push_bytes;
          state_d = StCheck;
        end
      end
      StCheck: begin
        cnt_d    = '0;
        popped_d = '0;
        ptr_d    = (func_q == FuncPop) ? rd_q : wr_q;
        if (count_q > CntW'(MaxBytes)) begin
          ok_d = 1'b0;
        end else if (func_q == FuncPush) begin
          ok_d = (count_ext <= room);
        end else begin
          ok_d = (count_ext <= fill);
        end
        if (!ok_d || count_q == '0) begin
          state_d = StDone;
        end else begin
          state_d = (func_q == FuncPop) ? StPop : StPush;
        end
      end
      StPush: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q;
        mem_o.wdata = data_q[7:0];
        data_d      = data_q >> 8;
        ptr_d       = ptr_q + 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_d == count_q) begin
          state_d = StDone;
        end
      end
      StPop: begin
        if (issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          ptr_d       = ptr_q + 1'b1;
          cnt_d       = cnt_q + 1'b1;
          rvld_d      = 1'b1;
          rlane_d     = cnt_q[LaneW-1:0];
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        wr_d    = new_wr;
        rd_d    = new_rd;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    rsp_o.accepted     = ok_q;
    rsp_o.popped_bytes = popped_q;
    rsp_o.fill_level   = new_wr - new_rd;
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wr_q    <= '0;
      rd_q    <= '0;
      rvld_q  <= 1'b0;
      cnt_q   <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
      func_q  <= FuncPush;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      rvld_q  <= rvld_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      func_q  <= func_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    rlane_q  <= rlane_d;
    popped_q <= popped_d;
  end

  a_write_only_in_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> state_q == StPush)
    else $error("byte store written outside a push");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == StIdle)
    else $error("sequencer did not return to idle after done");

  a_refused_holds_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_q) |=> ($stable(wr_q) && $stable(rd_q)))
    else $error("refused beat moved an index");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush || state_q == StPop) |-> cnt_q <= count_q)
    else $error("byte counter ran past the beat size");

  a_indices_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StDone) |=> ($stable(wr_q) && $stable(rd_q)))
    else $error("index moved outside the done step");

endmodule

@@ rtl/byte_ring_buffer_records_top.sv @@
// Byte ring buffer top level: result register around the sequencer and byte store.
// Depends on brb_pkg, brb_mem and brb_ctrl.
// Sequence: start is taken in idle, then the check step, then the push or pop byte steps
//   (skipped for a refused or empty beat), then done; valid_o is registered from done.
// Rate is one byte per cycle within a beat; a new beat is taken only while busy is low.
// Reset clears both indices and the sequencer; the store itself is not cleared.
// Results cannot be stalled: each is shown for exactly one cycle on valid_o.
`timescale 1ns / 1ps

module byte_ring_buffer_records_top
  import brb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  brb_req_t req_i,
  output logic     valid_o,
  output brb_rsp_t rsp_o
);

  brb_mem_cmd_t mem_cmd;
  logic [7:0]   mem_rdata;
  logic         done;
  brb_rsp_t     rsp;
  brb_rsp_t     rsp_q;
  logic         valid_q;

  brb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .rdata_i (mem_rdata),
    .busy_o  (busy),
    .done_o  (done),
    .rsp_o   (rsp),
    .mem_o   (mem_cmd)
  );

  brb_mem u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

@@ sim/tb_top.sv @@
// Testbench for byte_ring_buffer_records_top: directed then random push and pop commands
// with random gaps, checked beat by beat against a byte-level model of the ring held in a
// scoreboard class. Depends on brb_pkg and the RTL in rtl.
`timescale 1ns / 1ps

module tb_top;
  import brb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 1950;
  localparam int unsigned DrainWait  = 20;

  class ring_scoreboard;
    logic [7:0]      store [Depth];
    logic [IdxW-1:0] wr_idx;
    logic [IdxW-1:0] rd_idx;
    brb_rsp_t        pending [$];
    int unsigned     errors;
    int unsigned     n_push;
    int unsigned     n_pop;
    int unsigned     n_refused;
    int unsigned     n_wraps;
    int unsigned     peak_fill;

    function new();
      wr_idx    = '0;
      rd_idx    = '0;
      errors    = 0;
      n_push    = 0;
      n_pop     = 0;
      n_refused = 0;
      n_wraps   = 0;
      peak_fill = 0;
    endfunction

    function logic [IdxW-1:0] fill();
      return wr_idx - rd_idx;
    endfunction

    function void note_request(brb_req_t r);
      brb_rsp_t        e;
      int unsigned     level;
      int unsigned     room;
      int unsigned     i;
      logic [IdxW-1:0] a;
      logic [IdxW-1:0] nxt;
      e     = '0;
      level = fill();
      room  = Depth - 1 - level;
      if (r.byte_count <= MaxBytes && r.func == FuncPush && r.byte_count <= room) begin
        for (i = 0; i < r.byte_count; i++) begin
          a = wr_idx + IdxW'(i);
          store[a] = r.push_bytes[8*i +: 8];
        end
        nxt = wr_idx + IdxW'(r.byte_count);
        if (nxt < wr_idx) n_wraps++;
        wr_idx     = nxt;
        e.accepted = 1'b1;
        n_push++;
      end else if (r.byte_count <= MaxBytes && r.func == FuncPop && r.byte_count <= level) begin
        for (i = 0; i < r.byte_count; i++) begin
          a = rd_idx + IdxW'(i);
          e.popped_bytes[8*i +: 8] = store[a];
        end
        rd_idx     = rd_idx + IdxW'(r.byte_count);
        e.accepted = 1'b1;
        n_pop++;
      end else begin
        n_refused++;
      end
      e.fill_level = fill();
      if (e.fill_level > peak_fill) peak_fill = e.fill_level;
      pending.push_back(e);
    endfunction

    function void check_result(brb_rsp_t got);
      brb_rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.accepted !== e.accepted) begin
        $display("%0t: accepted mismatch: expected %b, actual %b", $time, e.accepted,
                 got.accepted);
        errors++;
      end
      if (got.popped_bytes !== e.popped_bytes) begin
        $display("%0t: popped_bytes mismatch: expected %h, actual %h", $time,
                 e.popped_bytes, got.popped_bytes);
        errors++;
      end
      if (got.fill_level !== e.fill_level) begin
        $display("%0t: fill_level mismatch: expected %0d, actual %0d", $time, e.fill_level,
                 got.fill_level);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  brb_req_t req_i;
  logic     valid_o;
  brb_rsp_t rsp_o;

  ring_scoreboard sb;
  int unsigned    cycles;
  int unsigned    burst_left;

  byte_ring_buffer_records_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(rsp_o);
  end

  function automatic brb_req_t make_cmd(logic func, int unsigned count, logic [DataW-1:0] data);
    brb_req_t r;
    r.func       = func;
    r.byte_count = CntW'(count);
    r.push_bytes = data;
    return r;
  endfunction

  function automatic brb_req_t rand_cmd(int unsigned push_pct);
    int unsigned count;
    if ($urandom_range(99) < 5) count = $urandom_range(15, MaxBytes + 1);
    else count = $urandom_range(MaxBytes);
    return make_cmd(($urandom_range(99) < push_pct) ? FuncPush : FuncPop, count,
                    {$urandom, $urandom});
  endfunction

  // hold the beat until the block takes it
  task automatic send_cmd(brb_req_t r);
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_request(r);
  endtask

  // drop start for a random gap at the end of each burst
  task automatic idle_after_beat();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      req_i <= make_cmd(1'($urandom), $urandom_range(15), {$urandom, $urandom});
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    brb_req_t    dir [$];
    int unsigned sent;
    int unsigned seg_len;
    int unsigned bias;
    bit          paused;
    sb         = new();
    cycles     = 0;
    burst_left = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    dir.push_back(make_cmd(FuncPop, 0, '0));
    dir.push_back(make_cmd(FuncPop, 1, '0));
    dir.push_back(make_cmd(FuncPush, 0, '1));
    dir.push_back(make_cmd(FuncPush, 8, '1));
    dir.push_back(make_cmd(FuncPush, 8, '0));
    dir.push_back(make_cmd(FuncPush, 15, '1));
    dir.push_back(make_cmd(FuncPush, 9, 64'h0123_4567_89ab_cdef));
    dir.push_back(make_cmd(FuncPop, 9, '1));
    dir.push_back(make_cmd(FuncPop, 15, '1));
    dir.push_back(make_cmd(FuncPush, 3, 64'hffff_ffff_ff5a_a55a));
    dir.push_back(make_cmd(FuncPop, 8, '1));
    dir.push_back(make_cmd(FuncPop, 8, '0));
    dir.push_back(make_cmd(FuncPop, 4, '0));
    dir.push_back(make_cmd(FuncPop, 3, '0));
    dir.push_back(make_cmd(FuncPop, 1, '0));
    dir.push_back(make_cmd(FuncPush, 1, 64'h8000_0000_0000_0080));
    dir.push_back(make_cmd(FuncPop, 0, '1));
    dir.push_back(make_cmd(FuncPop, 1, '1));
    dir.push_back(make_cmd(FuncPush, 7, 64'haaaa_5555_aaaa_5555));
    dir.push_back(make_cmd(FuncPush, 5, 64'h5555_aaaa_5555_aaaa));
    dir.push_back(make_cmd(FuncPop, 12, '0));
    dir.push_back(make_cmd(FuncPop, 7, '0));
    dir.push_back(make_cmd(FuncPop, 5, '0));
    foreach (dir[i]) begin
      send_cmd(dir[i]);
      idle_after_beat();
    end

    // alternate fill, drain and balanced stretches so the ring fills, empties and wraps
    sent   = 0;
    paused = 1'b0;
    bias   = 95;
    while (sent < RandItems) begin
      seg_len = $urandom_range(150, 350);
      repeat (seg_len) begin
        if (sent < RandItems) begin
          send_cmd(rand_cmd(bias));
          sent++;
          idle_after_beat();
          if (!paused && sent >= RandItems / 2) begin
            wait_drained();
            paused = 1'b1;
          end
        end
      end
      case ($urandom_range(2))
        0:       bias = 95;
        1:       bias = 10;
        default: bias = 55;
      endcase
    end

    wait_drained();
    $display("Ran %0d accepted pushes, %0d accepted pops and %0d refused commands.",
             sb.n_push, sb.n_pop, sb.n_refused);
    $display("Fill peaked at %0d bytes; write index wrapped %0d times.", sb.peak_fill,
             sb.n_wraps);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
